// ----- hdl/stick_deadzone_response_shaper_core_macros.svh -----
// ----------------------------------------------------------------------------
// Stick shaper assertion macros
// Shared concurrent assertion forms for the shaper checker.
// ----------------------------------------------------------------------------
`ifndef STICK_DEADZONE_RESPONSE_SHAPER_CORE_MACROS_SVH
`define STICK_DEADZONE_RESPONSE_SHAPER_CORE_MACROS_SVH

// Checked only out of reset.
`define SDZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stick shaper check failed");

// Checked on every edge, reset included.
`define SDZ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stick shaper reset check failed");

`endif

// ----- hdl/sdz_pkg.sv -----
// ----------------------------------------------------------------------------
// sdz_pkg
// Types, register codes and constant helpers for the stick shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package sdz_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DZ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP      = 2'd2;

  localparam logic [15:0] RST_DZ  = 16'd13107;
  localparam logic [15:0] RST_EXP = 16'd4096;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               req_type;
  } sdz_in_t;

  typedef struct packed {
    logic signed [15:0] shaped_x;
    logic signed [15:0] shaped_y;
  } sdz_out_t;

  // Normalized sample pair, Q16 magnitudes plus signs
  typedef struct packed {
    logic        req;
    logic        nx;
    logic        ny;
    logic [16:0] mx;
    logic [16:0] my;
  } sdz_side_t;

  typedef struct packed {
    sdz_side_t   side;
    logic [16:0] mag;
    logic        zero;
  } sdz_item_t;

  // Bitwise integer square root, elaboration use only
  function automatic logic [63:0] sdz_isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    logic [63:0] t;
    rem  = v;
    root = '0;
    for (int k = 0; k < 32; k++) begin
      b = 64'd1 << (62 - 2 * k);
      t = root + b;
      if (rem >= t) begin
        rem  = rem - t;
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
    end
    return root;
  endfunction

  // Q30 value of 0.5^(2^-idx), each root the floor sqrt of the previous
  function automatic logic [30:0] sdz_root(input int idx);
    logic [63:0] r;
    r = 64'(Q30_ONE >> 1);
    for (int k = 1; k <= 16; k++) begin
      if (k <= idx) begin
        r = sdz_isqrt64(r << 30);
      end
    end
    return r[30:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/stick_deadzone_response_shaper_core.sv -----
// ----------------------------------------------------------------------------
// stick_deadzone_response_shaper_core
// Radial deadzone and power response curve for signed 16-bit stick samples.
// ----------------------------------------------------------------------------
// One item enters per clock and one result leaves per clock; the pipeline
// depth from accept to a valid result is set by the bit-per-stage units: a
// 17-stage square root for the stick magnitude, a 16-stage deadzone rescale
// divider, 16 squaring stages for log2, 16 root-multiply stages for exp2 and
// a 16-stage divider that projects onto the direction. The whole pipe
// advances together and only holds while a finished result sits in the
// output register with out_stall high; in_stall mirrors that.
// Configuration writes (deadzones, exponent) are taken at any edge with
// cfg_we high, but must only happen while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_deadzone_response_shaper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sdz_pkg::sdz_in_t                    in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sdz_pkg::sdz_out_t                   out_item,
  input  logic                                cfg_we,
  input  logic [sdz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                         cfg_wdata
);
  import sdz_pkg::*;

  // Configuration registers: deadzones Q0.16, exponent Q4.12
  logic [15:0] stick_dz_r;
  logic [15:0] axis_dz_r;
  logic [15:0] expo_r;

  // Pipe-wide advance
  logic en;

  logic        mag_valid;
  sdz_side_t   mag_side;
  logic [16:0] mag_val;

  logic        rsc_valid;
  sdz_item_t   rsc_item;
  logic [16:0] rsc_n;

  logic        pow_valid;
  sdz_item_t   pow_item;
  logic [16:0] pow_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_dz_r <= RST_DZ;
      axis_dz_r  <= RST_DZ;
      expo_r     <= RST_EXP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STICK_DZ: stick_dz_r <= cfg_wdata;
        CFG_AXIS_DZ:  axis_dz_r  <= cfg_wdata;
        CFG_EXP:      expo_r     <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Output register is the last stage; hold everything while it is stuck.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Normalize and take the radial magnitude
  sdz_magnitude u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (mag_valid),
    .out_side  (mag_side),
    .out_mag   (mag_val)
  );

  // Deadzone test and rescale to 0..1 past the deadzone
  sdz_rescale u_rsc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mag_valid),
    .in_side   (mag_side),
    .in_mag    (mag_val),
    .stick_dz  (stick_dz_r),
    .axis_dz   (axis_dz_r),
    .out_valid (rsc_valid),
    .out_item  (rsc_item),
    .out_n     (rsc_n)
  );

  // Response curve n^e
  sdz_power u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rsc_valid),
    .in_item   (rsc_item),
    .in_n      (rsc_n),
    .expo      (expo_r),
    .out_valid (pow_valid),
    .out_item  (pow_item),
    .out_s     (pow_s)
  );

  // Back onto the axes, signs restored, into the output register
  sdz_project u_prj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pow_valid),
    .in_item   (pow_item),
    .in_s      (pow_s),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- hdl/sdz_magnitude.sv -----
// ----------------------------------------------------------------------------
// sdz_magnitude
// Sample normalization to Q16 and pipelined radial magnitude (isqrt).
// ----------------------------------------------------------------------------
`default_nettype none

module sdz_magnitude (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sdz_pkg::sdz_in_t    in_item,
  output logic                out_valid,
  output sdz_pkg::sdz_side_t  out_side,
  output logic [16:0]         out_mag
);
  import sdz_pkg::*;

  localparam int unsigned SQ_STEPS = 17;
  localparam int unsigned NS       = 3 + SQ_STEPS;

  logic [NS-1:0] vld_r;
  sdz_side_t     side_r [NS];
  sdz_side_t     side_nxt;
  logic [33:0]   sqx_r;
  logic [33:0]   sqy_r;
  logic [34:0]   rem_r  [SQ_STEPS+1];
  logic [34:0]   root_r [SQ_STEPS+1];
  logic [34:0]   rem_nxt  [SQ_STEPS];
  logic [34:0]   root_nxt [SQ_STEPS];
  logic [34:0]   sq_t     [SQ_STEPS];
  logic [17:0]   norm_x;
  logic [17:0]   norm_y;

  // {neg, |v| in Q16}; positive side divides by 32767 exactly
  function automatic logic [17:0] norm_q16(input logic [15:0] v);
    logic [16:0] a;
    logic [16:0] tw;
    logic [16:0] t;
    logic [16:0] ex;
    a  = 17'({1'b0, ~v}) + 17'd1;
    tw = {v, 1'b0};
    t  = tw + 17'd16383;
    ex = (t >= 17'd65534) ? 17'd2 : ((t >= 17'd32767) ? 17'd1 : 17'd0);
    if (v[15]) begin
      return {1'b1, a[15:0], 1'b0};
    end
    return {1'b0, tw + ex};
  endfunction

  assign norm_x = norm_q16(in_item.raw_x);
  assign norm_y = norm_q16(in_item.raw_y);

  always_comb begin
    side_nxt.req = in_item.req_type;
    side_nxt.nx  = norm_x[17];
    side_nxt.ny  = norm_y[17];
    side_nxt.mx  = norm_x[16:0];
    side_nxt.my  = norm_y[16:0];
  end

  // one result bit per stage, trial bit 4^(16-k)
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_t[k] = root_r[k] + (35'd1 << (32 - 2 * k));
      if (rem_r[k] >= sq_t[k]) begin
        rem_nxt[k]  = rem_r[k] - sq_t[k];
        root_nxt[k] = (root_r[k] >> 1) + (35'd1 << (32 - 2 * k));
      end else begin
        rem_nxt[k]  = rem_r[k];
        root_nxt[k] = root_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int j = 1; j < NS; j++) begin
        side_r[j] <= side_r[j-1];
      end
      sqx_r     <= 34'(side_r[0].mx) * 34'(side_r[0].mx);
      sqy_r     <= 34'(side_r[0].my) * 34'(side_r[0].my);
      rem_r[0]  <= 35'(sqx_r) + 35'(sqy_r);
      root_r[0] <= '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        root_r[k+1] <= root_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_side  = side_r[NS-1];
  assign out_mag   = root_r[SQ_STEPS][16:0];

endmodule

`default_nettype wire

// ----- hdl/sdz_rescale.sv -----
// ----------------------------------------------------------------------------
// sdz_rescale
// Deadzone test, clamp and pipelined rescale divide past the deadzone.
// ----------------------------------------------------------------------------
`default_nettype none

module sdz_rescale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sdz_pkg::sdz_side_t  in_side,
  input  logic [16:0]         in_mag,
  input  logic [15:0]         stick_dz,
  input  logic [15:0]         axis_dz,
  output logic                out_valid,
  output sdz_pkg::sdz_item_t  out_item,
  output logic [16:0]         out_n
);
  import sdz_pkg::*;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned NS        = 1 + DIV_STEPS;

  logic [NS-1:0] vld_r;
  sdz_item_t     it_r   [NS];
  logic [16:0]   rem_r  [NS];
  logic [15:0]   q_r    [NS];
  logic [16:0]   dv_r   [NS];
  logic          full_r [NS];
  logic [16:0]   rem_nxt [DIV_STEPS];
  logic [15:0]   q_nxt   [DIV_STEPS];
  logic [17:0]   rx      [DIV_STEPS];

  logic [16:0]   m_sel;
  logic [16:0]   d_sel;
  logic [16:0]   m_clip;
  logic [16:0]   num;
  logic [16:0]   dv;
  sdz_item_t     it_nxt;

  always_comb begin
    m_sel  = in_side.req ? in_side.mx : in_mag;
    d_sel  = 17'(in_side.req ? axis_dz : stick_dz);
    m_clip = (m_sel > Q16_ONE) ? Q16_ONE : m_sel;
    num    = m_clip - d_sel;
    dv     = Q16_ONE - d_sel;
    it_nxt.side = in_side;
    it_nxt.mag  = in_mag;
    it_nxt.zero = (m_sel <= d_sel) || (m_sel == '0);
  end

  // restoring divide, num < dv unless full scale or inside the deadzone
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rx[k] = {rem_r[k], 1'b0};
      if (rx[k] >= {1'b0, dv_r[k]}) begin
        rem_nxt[k] = 17'(rx[k] - {1'b0, dv_r[k]});
        q_nxt[k]   = {q_r[k][14:0], 1'b1};
      end else begin
        rem_nxt[k] = rx[k][16:0];
        q_nxt[k]   = {q_r[k][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0]   <= it_nxt;
      rem_r[0]  <= num;
      q_r[0]    <= '0;
      dv_r[0]   <= dv;
      full_r[0] <= (num == dv);
      for (int k = 0; k < DIV_STEPS; k++) begin
        it_r[k+1]   <= it_r[k];
        rem_r[k+1]  <= rem_nxt[k];
        q_r[k+1]    <= q_nxt[k];
        dv_r[k+1]   <= dv_r[k];
        full_r[k+1] <= full_r[k];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_item  = it_r[NS-1];
  assign out_n     = full_r[NS-1] ? Q16_ONE : {1'b0, q_r[NS-1]};

endmodule

`default_nettype wire

// ----- hdl/sdz_power.sv -----
// ----------------------------------------------------------------------------
// sdz_power
// Power curve n^e: log2 by repeated squaring, scale, exp2 by root products.
// ----------------------------------------------------------------------------
`default_nettype none

module sdz_power (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sdz_pkg::sdz_item_t  in_item,
  input  logic [16:0]         in_n,
  input  logic [15:0]         expo,
  output logic                out_valid,
  output sdz_pkg::sdz_item_t  out_item,
  output logic [16:0]         out_s
);
  import sdz_pkg::*;

  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned POW_STEPS = 16;
  localparam int unsigned NS        = 1 + LOG_STEPS + 1 + POW_STEPS + 1;

  logic [NS-1:0] vld_r;
  sdz_item_t     it_r [NS];

  logic [30:0]   z_r    [LOG_STEPS+1];
  logic [15:0]   frac_r [LOG_STEPS+1];
  logic [4:0]    msb_r  [LOG_STEPS+1];
  logic [30:0]   z_nxt    [LOG_STEPS];
  logic [15:0]   frac_nxt [LOG_STEPS];

  logic [23:0]   p_r [POW_STEPS+1];
  logic [30:0]   r_r [POW_STEPS+1];
  logic [30:0]   r_nxt [POW_STEPS];
  logic [16:0]   s_r;

  logic [4:0]    msb_c;
  logic [30:0]   z0;
  logic [20:0]   lg;
  logic [23:0]   p_nxt;
  logic [7:0]    ip;
  logic [30:0]   rs;
  logic [16:0]   s_nxt;

  always_comb begin
    msb_c = '0;
    for (int b = 1; b <= 16; b++) begin
      if (in_n[b]) begin
        msb_c = 5'(b);
      end
    end
    z0 = 31'(in_n) << (5'd30 - msb_c);
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    logic [61:0] sq;
    assign sq = 62'(z_r[g]) * 62'(z_r[g]);
    assign z_nxt[g]    = sq[61] ? sq[61:31] : sq[60:30];
    assign frac_nxt[g] = {frac_r[g][14:0], sq[61]};
  end

  // -log2 in Q16, then scaled by the Q4.12 exponent with rounding
  always_comb begin
    lg    = {5'd16 - msb_r[LOG_STEPS], 16'd0} - 21'(frac_r[LOG_STEPS]);
    p_nxt = 24'((37'(lg) * 37'(expo) + 37'd2048) >> 12);
  end

  for (genvar g = 0; g < POW_STEPS; g++) begin : g_pow
    localparam logic [30:0] ROOT = sdz_root(g + 1);
    logic [61:0] prod;
    assign prod     = 62'(r_r[g]) * 62'(ROOT);
    assign r_nxt[g] = p_r[g][POW_STEPS-1-g] ? prod[60:30] : r_r[g];
  end

  always_comb begin
    ip    = p_r[POW_STEPS][23:16];
    rs    = (ip >= 8'd31) ? '0 : (r_r[POW_STEPS] >> ip[4:0]);
    s_nxt = (expo == '0) ? Q16_ONE : 17'((32'(rs) + 32'd8192) >> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= in_item;
      for (int j = 1; j < NS; j++) begin
        it_r[j] <= it_r[j-1];
      end
      z_r[0]    <= z0;
      frac_r[0] <= '0;
      msb_r[0]  <= msb_c;
      for (int k = 0; k < LOG_STEPS; k++) begin
        z_r[k+1]    <= z_nxt[k];
        frac_r[k+1] <= frac_nxt[k];
        msb_r[k+1]  <= msb_r[k];
      end
      p_r[0] <= p_nxt;
      r_r[0] <= Q30_ONE;
      for (int k = 0; k < POW_STEPS; k++) begin
        p_r[k+1] <= p_r[k];
        r_r[k+1] <= r_nxt[k];
      end
      s_r <= s_nxt;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_item  = it_r[NS-1];
  assign out_s     = s_r;

endmodule

`default_nettype wire

// ----- hdl/sdz_project.sv -----
// ----------------------------------------------------------------------------
// sdz_project
// Applies the shaped magnitude along the direction; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdz_project (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sdz_pkg::sdz_item_t  in_item,
  input  logic [16:0]         in_s,
  output logic                out_valid,
  output sdz_pkg::sdz_out_t   out_item
);
  import sdz_pkg::*;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned NS        = 2 + DIV_STEPS + 1;

  logic [NS-1:0] vld_r;
  sdz_item_t     it_r [NS-1];
  logic [33:0]   ax_r;
  logic [33:0]   ay_r;
  logic [16:0]   s0_r;

  logic [17:0]   remx_r [DIV_STEPS+1];
  logic [17:0]   remy_r [DIV_STEPS+1];
  logic [15:0]   lox_r  [DIV_STEPS+1];
  logic [15:0]   loy_r  [DIV_STEPS+1];
  logic [15:0]   qx_r   [DIV_STEPS+1];
  logic [15:0]   qy_r   [DIV_STEPS+1];
  logic [15:0]   axo_r  [DIV_STEPS+1];
  logic [17:0]   remx_nxt [DIV_STEPS];
  logic [17:0]   remy_nxt [DIV_STEPS];
  logic [15:0]   qx_nxt   [DIV_STEPS];
  logic [15:0]   qy_nxt   [DIV_STEPS];

  sdz_out_t      out_r;
  sdz_out_t      out_nxt;

  logic [49:0]   bx_full;
  logic [49:0]   by_full;
  logic [32:0]   axis_t;
  logic [15:0]   ox;
  logic [15:0]   oy;

  // x*s*32767 + mag*32768, then the low 16 bits of the divisor mag*65536
  always_comb begin
    bx_full = 50'({ax_r, 15'd0} - 49'(ax_r)) + 50'({it_r[0].mag, 15'd0});
    by_full = 50'({ay_r, 15'd0} - 49'(ay_r)) + 50'({it_r[0].mag, 15'd0});
    axis_t  = 33'({s0_r, 15'd0}) - 33'(s0_r) + 33'd32768;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [17:0] tx;
    logic [17:0] ty;
    logic [17:0] dm;
    assign dm = 18'(it_r[g+1].mag);
    assign tx = {remx_r[g][16:0], lox_r[g][DIV_STEPS-1-g]};
    assign ty = {remy_r[g][16:0], loy_r[g][DIV_STEPS-1-g]};
    assign remx_nxt[g] = (tx >= dm) ? (tx - dm) : tx;
    assign remy_nxt[g] = (ty >= dm) ? (ty - dm) : ty;
    assign qx_nxt[g]   = {qx_r[g][14:0], tx >= dm};
    assign qy_nxt[g]   = {qy_r[g][14:0], ty >= dm};
  end

  always_comb begin
    ox = (qx_r[DIV_STEPS] > 16'd32767) ? 16'd32767 : qx_r[DIV_STEPS];
    oy = (qy_r[DIV_STEPS] > 16'd32767) ? 16'd32767 : qy_r[DIV_STEPS];
    out_nxt = '0;
    if (!it_r[NS-2].zero) begin
      if (it_r[NS-2].side.req) begin
        out_nxt.shaped_x = it_r[NS-2].side.nx ? 16'(16'd0 - axo_r[DIV_STEPS])
                                              : axo_r[DIV_STEPS];
      end else begin
        out_nxt.shaped_x = it_r[NS-2].side.nx ? 16'(16'd0 - ox) : ox;
        out_nxt.shaped_y = it_r[NS-2].side.ny ? 16'(16'd0 - oy) : oy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= in_item;
      for (int j = 1; j < NS - 1; j++) begin
        it_r[j] <= it_r[j-1];
      end
      ax_r <= 34'(in_item.side.mx) * 34'(in_s);
      ay_r <= 34'(in_item.side.my) * 34'(in_s);
      s0_r <= in_s;

      remx_r[0] <= bx_full[49:32];
      remy_r[0] <= by_full[49:32];
      lox_r[0]  <= bx_full[31:16];
      loy_r[0]  <= by_full[31:16];
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      axo_r[0]  <= axis_t[31:16];
      for (int k = 0; k < DIV_STEPS; k++) begin
        remx_r[k+1] <= remx_nxt[k];
        remy_r[k+1] <= remy_nxt[k];
        lox_r[k+1]  <= lox_r[k];
        loy_r[k+1]  <= loy_r[k];
        qx_r[k+1]   <= qx_nxt[k];
        qy_r[k+1]   <= qy_nxt[k];
        axo_r[k+1]  <= axo_r[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ----- hdl/sdz_checker.sv -----
// ----------------------------------------------------------------------------
// sdz_checker
// Port-level checks for the stick shaper, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stick_deadzone_response_shaper_core_macros.svh"

module sdz_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input sdz_pkg::sdz_in_t               in_item,
  input logic                           out_valid,
  input logic                           out_stall,
  input sdz_pkg::sdz_out_t              out_item
);

  // full-scale negative code, never produced
  logic x_min;
  logic y_min;

  assign x_min = (out_item.shaped_x == 16'h8000);
  assign y_min = (out_item.shaped_y == 16'h8000);

  // pipe empties on reset
  `SDZ_ASSERT_RST(a_rst_empty, !$past(rst_n) |-> !out_valid)

  // input only held back by a stuck result
  `SDZ_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall))

  // shaped values stay within plus/minus one
  `SDZ_ASSERT(a_out_range, out_valid |-> !(x_min || y_min))

  // a stalled result stays put
  `SDZ_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_item)))

  // a stalled input item stays put
  `SDZ_ASSERT(a_in_hold, (in_valid && in_stall) |=> (in_valid && $stable(in_item)))

endmodule

bind stick_deadzone_response_shaper_core sdz_checker u_sdz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Stick shaper testbench
// Drives stick and axis samples through the shaper with random gaps and output
// stalls. Each result is checked against an in-bench fixed-point predictor.
// Configuration is swept between phases, the extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdz_pkg::*;

  localparam int PIPE_DEPTH = 91;
  localparam int CYCLE_LIMIT = 400000;

  // Predictor copy of the three registers
  logic [15:0] pr_stick_dz, pr_axis_dz, pr_exp;
  logic [63:0] half_roots [0:16];

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // n in Q16, exponent Q4.12 -> n^e in Q16
  function automatic logic [31:0] power_q16(input logic [31:0] n, input logic [15:0] e);
    logic [63:0] z, r, lg, p;
    logic [31:0] msb, frac, ip, fp;
    if (e == 0) return 32'd65536;
    if (n == 0) return 0;
    msb = 0;
    while (msb < 16 && (n >> (msb + 1)) != 0) msb++;
    z = 64'(n) << (30 - msb);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      z = (z * z) >> 30;
      frac = frac << 1;
      if (z >= (64'd1 << 31)) begin
        z = z >> 1;
        frac = frac | 1;
      end
    end
    lg = 64'(16 - msb) * 65536 - frac;
    p = (lg * e + 2048) >> 12;
    ip = p[47:16];
    fp = {16'd0, p[15:0]};
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++)
      if (fp[16 - i]) r = (r * half_roots[i]) >> 30;
    r = (ip >= 31) ? 0 : (r >> ip);
    return 32'((r + 8192) >> 14);
  endfunction

  function automatic logic [31:0] norm_mag(input logic signed [15:0] v, output logic neg);
    neg = v < 0;
    if (neg) return 32'(-int'(v)) * 2;
    return 32'((64'(v) * 65536 + 16383) / 32767);
  endfunction

  function automatic logic [31:0] shape_mag(input logic [31:0] m, input logic [15:0] d);
    logic [63:0] n;
    if (m > 65536) m = 65536;
    if (m <= d) return 0;
    n = (64'(m - d) << 16) / (65536 - d);
    if (n > 65536) n = 65536;
    return power_q16(32'(n), pr_exp);
  endfunction

  function automatic logic [15:0] apply_sign(input logic [31:0] mag, input logic neg);
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic sdz_out_t shape_sample(input sdz_in_t it);
    sdz_out_t o;
    logic nx, ny;
    logic [31:0] mx, my, s, mag;
    logic [63:0] den, ox, oy;
    o = '0;
    mx = norm_mag(it.raw_x, nx);
    my = norm_mag(it.raw_y, ny);
    if (it.req_type) begin
      if (mx <= pr_axis_dz) return o;
      s = shape_mag(mx, pr_axis_dz);
      o.shaped_x = apply_sign(32'((64'(s) * 32767 + 32768) >> 16), nx);
      return o;
    end
    mag = 32'(sqrt_floor(64'(mx) * mx + 64'(my) * my));
    if (mag <= pr_stick_dz || mag == 0) return o;
    s = shape_mag(mag, pr_stick_dz);
    den = 64'(mag) * 65536;
    ox = (64'(mx) * s * 32767 + den / 2) / den;
    oy = (64'(my) * s * 32767 + den / 2) / den;
    if (ox > 32767) ox = 32767;
    if (oy > 32767) oy = 32767;
    o.shaped_x = apply_sign(32'(ox), nx);
    o.shaped_y = apply_sign(32'(oy), ny);
    return o;
  endfunction

  // Scoreboard: queue of predicted shaped samples
  class shaped_scoreboard;
    sdz_out_t pending[$];
    int errors;
    int checked;

    function void note_sample(sdz_out_t exp_out);
      pending.push_back(exp_out);
    endfunction

    function void check_result(sdz_out_t got);
      sdz_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", got.shaped_x, got.shaped_y);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.shaped_x !== want.shaped_x) begin
        $error("shaped_x expected %0d got %0d", want.shaped_x, got.shaped_x);
        errors++;
      end
      if (got.shaped_y !== want.shaped_y) begin
        $error("shaped_y expected %0d got %0d", want.shaped_y, got.shaped_y);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  sdz_in_t in_item;
  sdz_out_t out_item;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_wdata;
  shaped_scoreboard sb;
  int cycles;
  int n_stick, n_axis;

  stick_deadzone_response_shaper_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: random stall per item, check on accept
  initial begin
    int gap;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_item);
    end
  end

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_STICK_DZ: pr_stick_dz = val;
      CFG_AXIS_DZ:  pr_axis_dz  = val;
      CFG_EXP:      pr_exp      = val;
      default: ;
    endcase
  endtask

  // Let the pipe drain before touching the registers
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  // Sends one sample; gap drawn per item, valid held through stall
  task automatic send_sample(input sdz_in_t it, input bit may_idle);
    int gap;
    gap = may_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(shape_sample(it));
    if (it.req_type) n_axis++; else n_stick++;
  endtask

  function automatic logic [15:0] pick_edge16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return 16'(13107 / 2 + $urandom_range(0, 40) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic directed_set();
    logic [15:0] xs [0:6];
    sdz_in_t it;
    xs = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h1999, 16'hE667};
    for (int k = 0; k < 7; k++) begin
      it.raw_x = xs[k]; it.raw_y = xs[6 - k]; it.req_type = 1'b0;
      send_sample(it, 0);
      it.req_type = 1'b1;
      send_sample(it, 1);
    end
    // Corners of the square, past unit magnitude
    it = '{16'h8000, 16'h8000, 1'b0}; send_sample(it, 0);
    it = '{16'h7FFF, 16'h8000, 1'b0}; send_sample(it, 0);
    // Just inside and outside the default deadzone
    it = '{16'sd6553, 16'sd0, 1'b1}; send_sample(it, 0);
    it = '{16'sd6554, 16'sd0, 1'b1}; send_sample(it, 0);
    it = '{16'sd0, -16'sd6554, 1'b0}; send_sample(it, 1);
  endtask

  task automatic random_phase(input int count);
    sdz_in_t it;
    bit burst;
    for (int k = 0; k < count; k++) begin
      burst = (k % 60) < 15;  // stretches with no input gaps
      it.req_type = $urandom_range(0, 1);
      it.raw_x = ($urandom_range(0, 3) == 0) ? pick_edge16() : 16'($urandom);
      it.raw_y = ($urandom_range(0, 3) == 0) ? pick_edge16() : 16'($urandom);
      send_sample(it, !burst);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] stick_set [0:5];
    logic [15:0] axis_set  [0:5];
    logic [15:0] exp_set   [0:5];
    sb = new();
    half_roots[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) half_roots[i] = sqrt_floor(half_roots[i - 1] << 30);
    pr_stick_dz = 16'd13107;
    pr_axis_dz  = 16'd13107;
    pr_exp      = 16'd4096;
    n_stick = 0; n_axis = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first, with directed corners
    directed_set();
    random_phase(100);

    stick_set = '{16'd0, 16'hFFFF, 16'd32768, 16'd1000, 16'd13107, 16'd50000};
    axis_set  = '{16'hFFFF, 16'd0, 16'd20000, 16'd65000, 16'd1, 16'd7000};
    exp_set   = '{16'd0, 16'hFFFF, 16'd2048, 16'd1, 16'd12288, 16'd4096};
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_reg(CFG_STICK_DZ, stick_set[ph]);
      write_reg(CFG_AXIS_DZ, axis_set[ph]);
      write_reg(CFG_EXP, ph == 5 ? 16'($urandom) : exp_set[ph]);
      cfg_we <= 1'b0;
      if (ph == 0) begin
        directed_set();
      end
      random_phase(120);
    end

    wait_drained();
    $display("Covered %0d stick and %0d axis samples over 7 register settings, %0d checked.",
             n_stick, n_axis, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/sdz_pkg.sv
hdl/sdz_magnitude.sv
hdl/sdz_rescale.sv
hdl/sdz_power.sv
hdl/sdz_project.sv
hdl/stick_deadzone_response_shaper_core.sv
hdl/sdz_checker.sv
bench/tb.sv
